>>> rtl/jors_pkg.sv
package jors_pkg;

  localparam int unsigned MaxDepthDefault = 255;

  localparam logic [7:0] ChOpenBrace   = 8'h7B;
  localparam logic [7:0] ChCloseBrace  = 8'h7D;
  localparam logic [7:0] ChOpenBrack   = 8'h5B;
  localparam logic [7:0] ChCloseBrack  = 8'h5D;
  localparam logic [7:0] ChQuote       = 8'h22;
  localparam logic [7:0] ChBackslash   = 8'h5C;
  localparam logic [7:0] ChComma       = 8'h2C;
  localparam logic [7:0] ChSpace       = 8'h20;
  localparam logic [7:0] ChTab         = 8'h09;
  localparam logic [7:0] ChCr          = 8'h0D;
  localparam logic [7:0] ChLf          = 8'h0A;

  typedef enum logic [1:0] {
    ErrNone      = 2'd0,
    ErrNotObject = 2'd1,
    ErrBracket   = 2'd2,
    ErrTooDeep   = 2'd3
  } jors_err_e;

  typedef struct packed {
    logic       inside_record;
    logic       inside_string;
    logic       escape_pending;
    logic [7:0] nesting_level;
    logic       array_done;
    jors_err_e  error_latched;
  } jors_state_t;

  typedef struct packed {
    logic [7:0] record_byte;
    logic       byte_in_record;
    logic       record_first;
    logic       record_last;
    logic       stream_closed;
    jors_err_e  error_code;
  } jors_result_t;

endpackage

>>> rtl/jors_step.sv
module jors_step import jors_pkg::*; #(
  parameter int unsigned MAX_DEPTH = MaxDepthDefault
) (
  input  jors_state_t  state_q_i,
  input  logic [7:0]   data_byte_i,
  output jors_state_t  state_d_o,
  output jors_result_t result_o
);

  // usable limit is capped by the 8-bit depth counter
  localparam int unsigned LimitInt = (MAX_DEPTH > 255) ? 255 : ((MAX_DEPTH < 1) ? 1 : MAX_DEPTH);
  localparam logic [7:0]  Limit    = LimitInt[7:0];

  logic       is_space;
  logic       inrec;
  logic       first;
  logic       last;
  logic [7:0] c;

  assign c = data_byte_i;
  assign is_space = (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf)
                  || (c == ChComma);

  always_comb begin
    state_d_o = state_q_i;
    inrec     = 1'b0;
    first     = 1'b0;
    last      = 1'b0;
    if ((state_q_i.error_latched != ErrNone) || state_q_i.array_done) begin
      // frozen
    end else if (!state_q_i.inside_record) begin
      if (is_space) begin
      end else if (c == ChCloseBrack) begin
        state_d_o.array_done = 1'b1;
      end else if (c != ChOpenBrace) begin
        state_d_o.error_latched = ErrNotObject;
      end else begin
        state_d_o.inside_record  = 1'b1;
        state_d_o.nesting_level  = 8'd1;
        state_d_o.inside_string  = 1'b0;
        state_d_o.escape_pending = 1'b0;
        inrec = 1'b1;
        first = 1'b1;
      end
    end else begin
      inrec = 1'b1;
      if (state_q_i.inside_string) begin
        if (state_q_i.escape_pending) begin
          state_d_o.escape_pending = 1'b0;
        end else if (c == ChBackslash) begin
          state_d_o.escape_pending = 1'b1;
        end else if (c == ChQuote) begin
          state_d_o.inside_string = 1'b0;
        end
      end else if (c == ChQuote) begin
        state_d_o.inside_string = 1'b1;
      end else if ((c == ChOpenBrace) || (c == ChOpenBrack)) begin
        if (state_q_i.nesting_level >= Limit) begin
          state_d_o.error_latched = ErrTooDeep;
        end else begin
          state_d_o.nesting_level = state_q_i.nesting_level + 8'd1;
        end
      end else if ((c == ChCloseBrace) || (c == ChCloseBrack)) begin
        if (state_q_i.nesting_level <= 8'd1) begin
          if (c != ChCloseBrace) begin
            state_d_o.error_latched = ErrBracket;
          end else begin
            state_d_o.nesting_level  = 8'd0;
            state_d_o.inside_record  = 1'b0;
            state_d_o.inside_string  = 1'b0;
            state_d_o.escape_pending = 1'b0;
            last = 1'b1;
          end
        end else begin
          state_d_o.nesting_level = state_q_i.nesting_level - 8'd1;
        end
      end
    end
  end

  always_comb begin
    result_o.record_byte    = c;
    result_o.byte_in_record = inrec;
    result_o.record_first   = first;
    result_o.record_last    = last;
    result_o.stream_closed  = state_d_o.array_done;
    result_o.error_code     = state_d_o.error_latched;
  end

endmodule

>>> rtl/jors_obuf.sv
module jors_obuf import jors_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  jors_result_t push_data_i,
  output logic         ready_o,
  output logic         valid_o,
  input  logic         pop_ready_i,
  output jors_result_t data_o
);

  logic         main_valid_q, main_valid_d;
  logic         skid_valid_q, skid_valid_d;
  jors_result_t main_q, main_d;
  jors_result_t skid_q, skid_d;
  logic         pop;

  assign pop     = main_valid_q && pop_ready_i;
  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = 1'b0;
      end
    end
    if (push_i) begin
      if (!main_valid_d) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        // receiver stalled, park the word
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

>>> rtl/json_object_record_splitter.sv
// json object record splitter
// in channel: data_byte_i with in_valid_i / in_ready_o, one word per byte of the
// array body, starting just after its opening bracket.
// out channel: out_valid_o / out_ready_i with the byte passed through and its
// flags: byte_in_record_o, record_first_o, record_last_o, stream_closed_o and
// error_code_o (latched until reset).
// each result goes straight into the output buffer as its byte is accepted.
// throughput: one byte per cycle while in_ready_o is high; the next parser
// state is formed combinationally from the byte and the current state.
// a two-entry output buffer (result register plus skid word) lets a byte be
// taken while a result waits; when the receiver stalls for more than one
// word, in_ready_o drops until the skid word drains.
// reset clears the parser state, the latched error and both output entries.
// once an error is latched or the closing bracket is seen, further bytes are
// still accepted and answered but leave the state alone.
module json_object_record_splitter import jors_pkg::*; #(
  parameter int unsigned MAX_DEPTH = MaxDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] record_byte_o,
  output logic       byte_in_record_o,
  output logic       record_first_o,
  output logic       record_last_o,
  output logic       stream_closed_o,
  output logic [1:0] error_code_o
);

  jors_state_t  state_q, state_d;
  jors_result_t step_res;
  jors_result_t out_res;
  logic         accept;

  assign accept = in_valid_i && in_ready_o;

  jors_step #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_step (
    .state_q_i   (state_q),
    .data_byte_i (data_byte_i),
    .state_d_o   (state_d),
    .result_o    (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{inside_record: 1'b0, inside_string: 1'b0, escape_pending: 1'b0,
                   nesting_level: 8'd0, array_done: 1'b0, error_latched: ErrNone};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  jors_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (step_res),
    .ready_o     (in_ready_o),
    .valid_o     (out_valid_o),
    .pop_ready_i (out_ready_i),
    .data_o      (out_res)
  );

  assign record_byte_o    = out_res.record_byte;
  assign byte_in_record_o = out_res.byte_in_record;
  assign record_first_o   = out_res.record_first;
  assign record_last_o    = out_res.record_last;
  assign stream_closed_o  = out_res.stream_closed;
  assign error_code_o     = out_res.error_code;

  a_first_is_brace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && record_first_o) |-> (byte_in_record_o && record_byte_o == ChOpenBrace))
    else $error("record start not on an opening brace");

  a_closed_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stream_closed_o) |-> (error_code_o == ErrNone))
    else $error("closed stream reports an error");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.error_latched != ErrNone) |=> $stable(state_q))
    else $error("state changed after an error was latched");

  a_depth_in_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.inside_record == (state_q.nesting_level != 8'd0)))
    else $error("nesting level out of step with record state");

endmodule
